/* hdl/tccw_pkg.sv */
// Shared types and constants for the text console character writer.
package tccw_pkg;

  // Field widths fixed by the interface.
  localparam int CELL_W         = 16;
  localparam int CHAR_W         = 8;
  localparam int ATTR_W         = 8;
  localparam int ADDR_FIELD_W   = 13;
  localparam int CURSOR_FIELD_W = 13;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 8;

  // Command codes.
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Control characters and the blank used for erasing.
  localparam logic [CHAR_W-1:0] CH_BS      = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  // Configuration register indexes.
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_NARROW = 2'd0;
  localparam cfg_index_t REG_SHORT  = 2'd1;
  localparam cfg_index_t REG_ATTR   = 2'd2;

  // Divisor selection for the constant divider.
  typedef logic [1:0] div_sel_t;
  localparam div_sel_t DIV_WIDE   = 2'd0;
  localparam div_sel_t DIV_NARROW = 2'd1;
  localparam div_sel_t DIV_TAB    = 2'd2;

endpackage

/* hdl/text_console_char_writer_top.sv */
// Newline and tab pass the divider pipeline states, then the execute state; other
// puts and reads pass one execute state before the result word is registered. A new
// word is taken only once the last result word is handed over. A put that scrolls adds
// a scroll pass: the cell store has one read and one write port, so the scroll moves
// one cell per cycle. Reset (synchronous, rst_n low) clears the cursor and configuration
// registers, then a clearing pass zeroes the store before input is taken.
module text_console_char_writer_top #(
  parameter int MAX_COLUMNS = 80,
  parameter int MAX_ROWS    = 60,
  parameter int TAB_WIDTH   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [tccw_pkg::CHAR_W-1:0]         in_character,
  input  logic [tccw_pkg::ADDR_FIELD_W-1:0]   in_read_address,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tccw_pkg::CURSOR_FIELD_W-1:0] out_cursor,
  output logic                                out_scrolled,
  output logic [tccw_pkg::CELL_W-1:0]         out_cell_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  tccw_pkg::cfg_index_t                cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tccw_pkg::*;

  localparam int CELLS    = MAX_COLUMNS * MAX_ROWS;
  localparam int AW       = $clog2(CELLS);
  localparam int CW       = $clog2(CELLS + MAX_COLUMNS + TAB_WIDTH + 1);
  localparam int W_WIDE   = MAX_COLUMNS;
  localparam int W_NARROW = MAX_COLUMNS / 2;
  localparam int H_TALL   = MAX_ROWS;
  localparam int H_SHORT  = (MAX_ROWS / 2 < 2) ? 2 : MAX_ROWS / 2;

  // Per-mode scroll threshold, home position after a scroll, and screen size.
  localparam logic [CW-1:0] LIM_WT  = CW'(W_WIDE * (H_TALL - 1));
  localparam logic [CW-1:0] LIM_WS  = CW'(W_WIDE * (H_SHORT - 1));
  localparam logic [CW-1:0] LIM_NT  = CW'(W_NARROW * (H_TALL - 1));
  localparam logic [CW-1:0] LIM_NS  = CW'(W_NARROW * (H_SHORT - 1));
  localparam logic [CW-1:0] HOME_WT = CW'(W_WIDE * (H_TALL - 2));
  localparam logic [CW-1:0] HOME_WS = CW'(W_WIDE * (H_SHORT - 2));
  localparam logic [CW-1:0] HOME_NT = CW'(W_NARROW * (H_TALL - 2));
  localparam logic [CW-1:0] HOME_NS = CW'(W_NARROW * (H_SHORT - 2));
  localparam logic [CW-1:0] TOT_WT  = CW'(W_WIDE * H_TALL);
  localparam logic [CW-1:0] TOT_WS  = CW'(W_WIDE * H_SHORT);
  localparam logic [CW-1:0] TOT_NT  = CW'(W_NARROW * H_TALL);
  localparam logic [CW-1:0] TOT_NS  = CW'(W_NARROW * H_SHORT);
  localparam logic [CW-1:0] CELLS_C = CW'(CELLS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_DIVA   = 3'd4;
  localparam logic [2:0] S_DIVB   = 3'd5;
  localparam logic [2:0] S_SCROLL = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       cursor_r, cursor_nxt;
  logic [CHAR_W-1:0]   ch_r, ch_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic                narrow_r, narrow_nxt;
  logic                short_r, short_nxt;
  logic [ATTR_W-1:0]   attr_r, attr_nxt;
  logic                sw_v_r, sw_v_nxt;
  logic                sw_copy_r, sw_copy_nxt;
  logic [AW-1:0]       sw_a_r, sw_a_nxt;
  logic                res_scrolled_r, res_scrolled_nxt;
  logic [CELL_W-1:0]   res_data_r, res_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CURSOR_FIELD_W-1:0] out_cursor_r, out_cursor_nxt;
  logic                out_scrolled_r, out_scrolled_nxt;
  logic [CELL_W-1:0]   out_cell_data_r, out_cell_data_nxt;

  logic [CW-1:0]       w_cur, lim_cur, home_cur, total_cur;
  logic [CW-1:0]       cur_calc;
  logic [CW-1:0]       scan_addr;
  logic [CW-1:0]       div_rem;
  div_sel_t            div_sel;
  logic                out_free;
  logic                finish;
  logic                fin_scrolled;
  logic [CELL_W-1:0]   fin_data;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [CELL_W-1:0]   mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [CELL_W-1:0]   mem_rdata;

  // Screen geometry for the current mode.
  always_comb begin
    unique case ({narrow_r, short_r})
      2'b00: begin
        w_cur = CW'(W_WIDE);   lim_cur = LIM_WT; home_cur = HOME_WT; total_cur = TOT_WT;
      end
      2'b01: begin
        w_cur = CW'(W_WIDE);   lim_cur = LIM_WS; home_cur = HOME_WS; total_cur = TOT_WS;
      end
      2'b10: begin
        w_cur = CW'(W_NARROW); lim_cur = LIM_NT; home_cur = HOME_NT; total_cur = TOT_NT;
      end
      default: begin
        w_cur = CW'(W_NARROW); lim_cur = LIM_NS; home_cur = HOME_NS; total_cur = TOT_NS;
      end
    endcase
  end

  // Newline needs the column, tab needs the offset within the tab stop.
  assign div_sel = (ch_r == CH_TAB) ? DIV_TAB : (narrow_r ? DIV_NARROW : DIV_WIDE);

  tccw_div_const #(
    .XW       (CW),
    .D_WIDE   (W_WIDE),
    .D_NARROW (W_NARROW),
    .D_TAB    (TAB_WIDTH)
  ) u_div (
    .clk (clk),
    .sel (div_sel),
    .x   (cursor_r),
    .rem (div_rem)
  );

  tccw_cell_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign scan_addr = cnt_r + w_cur;

  // Configuration writes.
  always_comb begin
    narrow_nxt = narrow_r;
    short_nxt  = short_r;
    attr_nxt   = attr_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_NARROW: narrow_nxt = cfg_data[0];
        REG_SHORT:  short_nxt  = cfg_data[0];
        REG_ATTR:   attr_nxt   = cfg_data;
        default: ;
      endcase
    end
  end

  // Command sequencer with the cell store read-modify-write traffic.
  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    cursor_nxt        = cursor_r;
    ch_nxt            = ch_r;
    rd_ok_nxt         = rd_ok_r;
    sw_v_nxt          = 1'b0;
    sw_copy_nxt       = sw_copy_r;
    sw_a_nxt          = sw_a_r;
    res_scrolled_nxt  = res_scrolled_r;
    res_data_nxt      = res_data_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_cursor_nxt    = out_cursor_r;
    out_scrolled_nxt  = out_scrolled_r;
    out_cell_data_nxt = out_cell_data_r;
    mem_we            = 1'b0;
    mem_waddr         = '0;
    mem_wdata         = '0;
    mem_raddr         = AW'(in_read_address);
    finish            = 1'b0;
    fin_scrolled      = 1'b0;
    fin_data          = '0;
    cur_calc          = cursor_r;

    // Write side of the scroll pipeline: copy the row below, or blank the last row.
    if (sw_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = sw_a_r;
      mem_wdata = sw_copy_r ? mem_rdata : {BLANK_CHAR, attr_r};
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = '0;
        if (cnt_r == CELLS_C - CW'(1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ch_nxt    = in_character;
          rd_ok_nxt = (32'(in_read_address) < 32'(CELLS));
          if (in_command == CMD_READ) begin
            state_nxt = S_RD;
          end else if (in_character == CH_LF || in_character == CH_TAB) begin
            state_nxt = S_DIVA;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_RD: begin
        finish   = 1'b1;
        fin_data = rd_ok_r ? mem_rdata : '0;
      end
      S_DIVA: begin
        state_nxt = S_DIVB;
      end
      S_DIVB: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (ch_r)
          CH_CR: begin
            cur_calc = cursor_r;
          end
          CH_LF: begin
            cur_calc = cursor_r - div_rem + w_cur;
          end
          CH_TAB: begin
            cur_calc = cursor_r + CW'(TAB_WIDTH) - div_rem;
          end
          CH_BS: begin
            // At the home position backspace does nothing.
            if (cursor_r != '0) begin
              cur_calc = cursor_r - CW'(1);
              if (cur_calc < CELLS_C) begin
                mem_we    = 1'b1;
                mem_waddr = cur_calc[AW-1:0];
                mem_wdata = {BLANK_CHAR, attr_r};
              end
            end
          end
          default: begin
            if (cursor_r < CELLS_C) begin
              mem_we    = 1'b1;
              mem_waddr = cursor_r[AW-1:0];
              mem_wdata = {ch_r, attr_r};
            end
            cur_calc = cursor_r + CW'(1);
          end
        endcase
        cursor_nxt = cur_calc;
        if (cur_calc >= lim_cur) begin
          cnt_nxt   = '0;
          state_nxt = S_SCROLL;
        end else begin
          finish = 1'b1;
        end
      end
      S_SCROLL: begin
        // Read side: one cell per cycle, written back in the next cycle.
        if (cnt_r < total_cur) begin
          sw_v_nxt    = 1'b1;
          sw_a_nxt    = cnt_r[AW-1:0];
          sw_copy_nxt = (cnt_r < lim_cur);
          if (cnt_r < lim_cur) begin
            mem_raddr = scan_addr[AW-1:0];
          end
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          cursor_nxt   = home_cur;
          finish       = 1'b1;
          fin_scrolled = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_cursor_nxt    = CURSOR_FIELD_W'(cursor_r);
          out_scrolled_nxt  = res_scrolled_r;
          out_cell_data_nxt = res_data_r;
          state_nxt         = S_IDLE;
        end
      end
    endcase

    // Hand the result word to the output register, or park it until there is room.
    if (finish) begin
      if (out_free) begin
        out_valid_nxt     = 1'b1;
        out_cursor_nxt    = CURSOR_FIELD_W'(cursor_nxt);
        out_scrolled_nxt  = fin_scrolled;
        out_cell_data_nxt = fin_data;
        state_nxt         = S_IDLE;
      end else begin
        res_scrolled_nxt = fin_scrolled;
        res_data_nxt     = fin_data;
        state_nxt        = S_OUT;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      cursor_r    <= '0;
      narrow_r    <= 1'b0;
      short_r     <= 1'b0;
      attr_r      <= '0;
      sw_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cursor_r    <= cursor_nxt;
      narrow_r    <= narrow_nxt;
      short_r     <= short_nxt;
      attr_r      <= attr_nxt;
      sw_v_r      <= sw_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ch_r            <= ch_nxt;
    rd_ok_r         <= rd_ok_nxt;
    sw_copy_r       <= sw_copy_nxt;
    sw_a_r          <= sw_a_nxt;
    res_scrolled_r  <= res_scrolled_nxt;
    res_data_r      <= res_data_nxt;
    out_cursor_r    <= out_cursor_nxt;
    out_scrolled_r  <= out_scrolled_nxt;
    out_cell_data_r <= out_cell_data_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_cursor    = out_cursor_r;
  assign out_scrolled  = out_scrolled_r;
  assign out_cell_data = out_cell_data_r;

endmodule

/* hdl/tccw_cell_mem.sv */
// Screen cell store: one write port and one registered read port.
module tccw_cell_mem #(
  parameter int DEPTH = 4800,
  parameter int AW    = 13
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [tccw_pkg::CELL_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [tccw_pkg::CELL_W-1:0] rdata
);
  import tccw_pkg::*;

  logic [CELL_W-1:0] cells [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  // Write first port, read second port; read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
    rdata_r <= cells[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/tccw_div_const.sv */
// Remainder of the cursor by one of three constant divisors, by reciprocal multiply.
module tccw_div_const #(
  parameter int XW       = 14,
  parameter int D_WIDE   = 80,
  parameter int D_NARROW = 40,
  parameter int D_TAB    = 8
) (
  input  logic               clk,
  input  tccw_pkg::div_sel_t sel,
  input  logic [XW-1:0]      x,
  output logic [XW-1:0]      rem
);
  import tccw_pkg::*;

  localparam int MW = XW + 1;
  localparam int PW = XW + MW;
  localparam logic [MW-1:0] M_WIDE   = MW'((1 << XW) / D_WIDE);
  localparam logic [MW-1:0] M_NARROW = MW'((1 << XW) / D_NARROW);
  localparam logic [MW-1:0] M_TAB    = MW'((1 << XW) / D_TAB);

  logic [MW-1:0] m_sel;
  logic [XW-1:0] d_sel;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [XW-1:0] qd_r, qd_nxt;
  logic [XW-1:0] q_est;
  logic [XW-1:0] r_raw;

  // Reciprocal and divisor for the selected case.
  always_comb begin
    unique case (sel)
      DIV_NARROW: begin
        m_sel = M_NARROW;
        d_sel = XW'(D_NARROW);
      end
      DIV_TAB: begin
        m_sel = M_TAB;
        d_sel = XW'(D_TAB);
      end
      default: begin
        m_sel = M_WIDE;
        d_sel = XW'(D_WIDE);
      end
    endcase
  end

  // Stage one scales by the reciprocal; stage two forms the estimated quotient times
  // the divisor. The estimate is low by at most one.
  assign prod_nxt = PW'(x) * PW'(m_sel);
  assign q_est    = XW'(prod_r >> XW);
  assign qd_nxt   = q_est * d_sel;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    qd_r   <= qd_nxt;
  end

  // One correcting subtract brings the remainder below the divisor.
  assign r_raw = x - qd_r;
  assign rem   = (r_raw >= d_sel) ? (r_raw - d_sel) : r_raw;

endmodule

/* hdl/tccw_checker.sv */
// Port-level checks for the text console character writer, bound to the top level.
module tccw_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_command,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [tccw_pkg::CURSOR_FIELD_W-1:0] out_cursor,
  input logic                                out_scrolled,
  input logic [tccw_pkg::CELL_W-1:0]         out_cell_data
);
  import tccw_pkg::*;

  logic                      acc_in;
  logic                      acc_out;
  logic [1:0]                pend_r;
  logic                      last_read_r;
  logic [CURSOR_FIELD_W-1:0] prev_cursor_r;

  assign acc_in  = in_valid && in_ready;
  assign acc_out = out_valid && out_ready;

  // Words accepted but not yet delivered, kind of the newest one, last cursor seen.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r        <= 2'd0;
      last_read_r   <= 1'b0;
      prev_cursor_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(acc_in) - 2'(acc_out);
      if (acc_in) begin
        last_read_r <= (in_command == CMD_READ);
      end
      if (acc_out) begin
        prev_cursor_r <= out_cursor;
      end
    end
  end

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor) &&
      $stable(out_scrolled) && $stable(out_cell_data))
    else $error("result word changed while stalled");

  // Every result comes from an accepted word, and at most two are in flight.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3 && (!out_valid || pend_r != 2'd0))
    else $error("result without a matching accepted word");

  // Reset leaves no result and takes no input right after it.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("activity right after reset");

  // A read neither scrolls nor moves the cursor.
  a_read_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pend_r == 2'd1 && last_read_r |->
      !out_scrolled && out_cursor == prev_cursor_r)
    else $error("read command changed the cursor or scrolled");

endmodule

bind text_console_char_writer_top tccw_checker u_tccw_checker (.*);

/* sim/tb_text_console_char_writer_top.sv */
// Self-checking testbench for the text console character writer: mirrored screen and cursor.
module tb_text_console_char_writer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  localparam int MAX_COLUMNS    = 80;
  localparam int MAX_ROWS       = 60;
  localparam int TAB_WIDTH      = 8;
  localparam int CELLS          = MAX_COLUMNS * MAX_ROWS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASES         = 12;
  localparam int PHASE_WORDS    = 150;

  // One result word as the block should present it.
  typedef struct {
    logic [CURSOR_FIELD_W-1:0] cursor;
    logic                      scrolled;
    logic [CELL_W-1:0]         data;
  } console_word_t;

  // Mirror of the screen store, cursor and registers, plus the words still owed.
  class console_mirror;
    int unsigned       cursor_pos;
    logic [CELL_W-1:0] cells [CELLS];
    bit                half_cols;
    bit                half_rows;
    logic [ATTR_W-1:0] attr;
    console_word_t     awaited [$];
    int                errors;

    function new();
      cursor_pos = 0;
      foreach (cells[i]) cells[i] = '0;
      half_cols = 0;
      half_rows = 0;
      attr = '0;
      errors = 0;
    endfunction

    function int unsigned cols();
      return half_cols ? MAX_COLUMNS / 2 : MAX_COLUMNS;
    endfunction

    function int unsigned rows();
      int unsigned h;
      h = half_rows ? MAX_ROWS / 2 : MAX_ROWS;
      return (h < 2) ? 2 : h;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_NARROW: half_cols = value[0];
        REG_SHORT:  half_rows = value[0];
        REG_ATTR:   attr = value;
        default: ;
      endcase
    endfunction

    // Writes outside the store are dropped.
    function void write_cell(int unsigned idx, logic [CHAR_W-1:0] ch);
      if (idx < CELLS) cells[idx] = {ch, attr};
    endfunction

    // Applies one accepted command and queues the word it must produce.
    function void note_command(logic cmd, logic [CHAR_W-1:0] ch,
                               logic [ADDR_FIELD_W-1:0] addr);
      console_word_t w;
      int unsigned   c;
      int unsigned   r;
      w.cursor = '0;
      w.scrolled = 1'b0;
      w.data = '0;
      c = cols();
      r = rows();
      if (cmd == CMD_READ) begin
        if (addr < CELLS) w.data = cells[addr];
      end else begin
        case (ch)
          CH_CR: ;
          CH_LF: cursor_pos = (cursor_pos / c) * c + c;
          CH_TAB: cursor_pos = cursor_pos + TAB_WIDTH - (cursor_pos % TAB_WIDTH);
          CH_BS: begin
            // Backspace at the home position leaves everything alone.
            if (cursor_pos != 0) begin
              cursor_pos = cursor_pos - 1;
              write_cell(cursor_pos, BLANK_CHAR);
            end
          end
          default: begin
            write_cell(cursor_pos, ch);
            cursor_pos = cursor_pos + 1;
          end
        endcase
        // Reaching the last row moves every row up and blanks the bottom one.
        if (cursor_pos / c >= r - 1) begin
          for (int unsigned i = 0; i < c * (r - 1); i++) cells[i] = cells[i + c];
          for (int unsigned i = c * (r - 1); i < c * r; i++) write_cell(i, BLANK_CHAR);
          cursor_pos = c * (r - 2);
          w.scrolled = 1'b1;
        end
      end
      w.cursor = cursor_pos[CURSOR_FIELD_W-1:0];
      awaited.push_back(w);
    endfunction

    // Compares one result word with the oldest owed word.
    function void check_word(logic [CURSOR_FIELD_W-1:0] cursor, logic scrolled,
                             logic [CELL_W-1:0] data);
      console_word_t w;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t unexpected result word: cursor %0d scrolled %0d cell %h",
                 $time, cursor, scrolled, data);
        return;
      end
      w = awaited.pop_front();
      if (cursor !== w.cursor) begin
        errors++;
        $display("%0t cursor mismatch: expected %0d, actual %0d", $time, w.cursor, cursor);
      end
      if (scrolled !== w.scrolled) begin
        errors++;
        $display("%0t scrolled mismatch: expected %0d, actual %0d",
                 $time, w.scrolled, scrolled);
      end
      if (data !== w.data) begin
        errors++;
        $display("%0t cell_data mismatch: expected %h, actual %h", $time, w.data, data);
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_command;
  logic [CHAR_W-1:0]         in_character;
  logic [ADDR_FIELD_W-1:0]   in_read_address;
  logic                      out_valid;
  logic                      out_ready;
  logic [CURSOR_FIELD_W-1:0] out_cursor;
  logic                      out_scrolled;
  logic [CELL_W-1:0]         out_cell_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  cfg_index_t                cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  bit in_stall;
  bit out_stall;
  int idle_cycles;

  console_mirror board = new();

  text_console_char_writer_top #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_character(in_character),
    .in_read_address(in_read_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_cursor(out_cursor),
    .out_scrolled(out_scrolled),
    .out_cell_data(out_cell_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one command word; valid is lowered only when a gap is taken.
  task automatic send_word(logic cmd, logic [CHAR_W-1:0] ch, logic [ADDR_FIELD_W-1:0] addr);
    int gap;
    gap = in_stall ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_character    <= ch;
    in_read_address <= addr;
    do @(posedge clk); while (in_ready !== 1'b1);
    board.note_command(cmd, ch, addr);
  endtask

  // Writes one configuration register.
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
    int gap;
    gap = in_stall ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.write_register(idx, value);
  endtask

  // Sets all three registers; the one-bit ones get random upper data bits.
  task automatic set_mode(bit narrow, bit short_sel, logic [ATTR_W-1:0] attr_val);
    logic [6:0] junk;
    junk = 7'($urandom_range(0, 127));
    write_reg(REG_NARROW, {junk, narrow});
    junk = 7'($urandom_range(0, 127));
    write_reg(REG_SHORT, {junk, short_sel});
    write_reg(REG_ATTR, attr_val);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering input and waits until every owed word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result side: random ready stalls, one check per accepted word.
  initial begin
    int gap;
    out_ready <= 1'b0;
    forever begin
      gap = out_stall ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      board.check_word(out_cursor, out_scrolled, out_cell_data);
    end
  end

  // Watchdog on cycles in which no channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t timeout: no word moved for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Main sequence: directed words, then phases of random traffic under varied modes.
  initial begin
    int                      pick;
    int                      lf_pct;
    int unsigned             span;
    bit                      narrow;
    bit                      short_sel;
    logic [ATTR_W-1:0]       attr_val;
    logic                    cmd;
    logic [CHAR_W-1:0]       ch;
    logic [ADDR_FIELD_W-1:0] addr;

    idle_cycles     = 0;
    in_stall        = 1'b1;
    out_stall       = 1'b1;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_command      <= CMD_PUT;
    in_character    <= '0;
    in_read_address <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_NARROW;
    cfg_data        <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at full size with a visible attribute.
    set_mode(1'b0, 1'b0, 8'hC3);
    send_word(CMD_READ, 8'hFF, 13'd0);
    send_word(CMD_READ, 8'h00, 13'd4799);
    send_word(CMD_READ, 8'hFF, 13'h1FFF);
    send_word(CMD_READ, 8'h00, 13'd4800);
    send_word(CMD_PUT, CH_BS, 13'h1FFF);
    send_word(CMD_PUT, CH_CR, 13'h0000);
    send_word(CMD_PUT, 8'h00, 13'h1FFF);
    send_word(CMD_PUT, 8'hFF, 13'h0000);
    send_word(CMD_PUT, 8'h41, 13'h0AAA);
    send_word(CMD_PUT, CH_TAB, 13'h1555);
    send_word(CMD_PUT, CH_BS, 13'h0000);
    send_word(CMD_PUT, CH_LF, 13'h1FFF);
    send_word(CMD_PUT, 8'h7F, 13'h0000);
    send_word(CMD_PUT, CH_TAB, 13'h0000);
    send_word(CMD_PUT, CH_TAB, 13'h0000);
    send_word(CMD_READ, 8'h00, 13'd0);
    send_word(CMD_READ, 8'h00, 13'd1);
    send_word(CMD_READ, 8'h00, 13'd2);
    send_word(CMD_READ, 8'h00, 13'd7);
    send_word(CMD_READ, 8'h00, 13'd80);
    send_word(CMD_READ, 8'hAA, 13'd4096);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin narrow = 1'b0; short_sel = 1'b0; attr_val = 8'h00; end
        1: begin narrow = 1'b1; short_sel = 1'b1; attr_val = 8'hFF; end
        2: begin narrow = 1'b0; short_sel = 1'b1; attr_val = 8'h5A; end
        3: begin narrow = 1'b1; short_sel = 1'b0; attr_val = 8'hA5; end
        default: begin
          narrow    = 1'($urandom_range(0, 1));
          short_sel = 1'($urandom_range(0, 1));
          attr_val  = ATTR_W'($urandom_range(0, 255));
        end
      endcase
      set_mode(narrow, short_sel, attr_val);
      // Every third phase runs back to back on both sides.
      in_stall  = (phase % 3 != 2);
      out_stall = (phase % 3 != 2);
      // Newline-heavy phases push the cursor deep so that a later mode change scrolls.
      lf_pct = (phase % 2 == 0) ? 30 : 10;
      span = board.cols() * board.rows();
      repeat (PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        cmd  = CMD_PUT;
        ch   = CHAR_W'($urandom_range(0, 255));
        addr = ADDR_FIELD_W'($urandom_range(0, 8191));
        if (pick < lf_pct) ch = CH_LF;
        else if (pick < lf_pct + 8) ch = CH_TAB;
        else if (pick < lf_pct + 16) ch = CH_BS;
        else if (pick < lf_pct + 20) ch = CH_CR;
        else if (pick < lf_pct + 38) begin
          cmd = CMD_READ;
          if ($urandom_range(0, 3) != 0) addr = ADDR_FIELD_W'($urandom_range(0, span - 1));
        end
        send_word(cmd, ch, addr);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
